@@ hdl/utf8_pkg.sv @@
// ============================================================================
// utf8_pkg
// Shared types and constants for the byte-serial UTF-8 stream decoder.
// ============================================================================
package utf8_pkg;

    localparam int unsigned CP_W     = 31;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned REM_W    = 3;
    localparam int unsigned CONT_W   = 6;

    // Replacement character for a bad lead byte
    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 31'h0000_FFFD;

    // Lead byte class masks and patterns
    localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MASK  = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD5_PAT   = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MASK  = 8'hFE;
    localparam logic [BYTE_W-1:0] LEAD6_PAT   = 8'hFC;

    // One result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_char;
        logic            bad_lead;
        logic            truncated;
        logic            end_of_text;
    } result_t;

endpackage

@@ hdl/utf8_stream_decoder.sv @@
// ============================================================================
// utf8_stream_decoder
// Byte-serial decoder for 31-bit UTF-8 (1 to 6 byte sequences).
// ============================================================================
// Usage:
//   Input channel  : byte_value / last_byte with in_valid / in_ready.
//   Output channel : code_point, has_char, bad_lead, truncated, end_of_text
//                    with out_valid / out_ready.
//   Each input byte gives zero or one result item. A result is registered in
//   the output register, or in the skid register while the output stalls.
//   Throughput is one byte per clock while in_ready is high; the per-byte
//   step is a mask, shift and OR on the accumulator, done combinationally
//   between the state registers and the output register.
//   Stall: when the receiver holds out_ready low, one more result is parked
//   in a skid register; in_ready drops only while that skid entry is full,
//   so a stalled receiver costs at most one extra held item.
//   Reset (rst_n low, asynchronous): accumulator, pending continuation count
//   and the terminator flag clear, and both output slots empty.
//   A zero lead byte ends the string; following bytes give no result until
//   the byte marked last, after which a new buffer begins.
// ============================================================================
module utf8_stream_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [utf8_pkg::BYTE_W-1:0]     byte_value,
    input  logic                            last_byte,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [utf8_pkg::CP_W-1:0]       code_point,
    output logic                            has_char,
    output logic                            bad_lead,
    output logic                            truncated,
    output logic                            end_of_text
);

    // Decoder state
    logic [utf8_pkg::CP_W-1:0]  acc_reg,  acc_next;
    logic [utf8_pkg::REM_W-1:0] rem_reg,  rem_next;
    logic                       term_reg, term_next;

    // Output register and skid entry
    utf8_pkg::result_t out_reg,  out_next;
    utf8_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg,  out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    // Step results
    utf8_pkg::result_t          res;
    logic                       res_valid;
    logic                       in_fire;
    logic [utf8_pkg::CP_W-1:0]  acc_shift;
    logic [utf8_pkg::REM_W-1:0] rem_dec;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    assign acc_shift = {acc_reg[utf8_pkg::CP_W-utf8_pkg::CONT_W-1:0],
                        byte_value[utf8_pkg::CONT_W-1:0]};
    assign rem_dec   = rem_reg - 3'd1;

    // Per-byte decode step
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        term_next = term_reg;

        if (term_reg)
        begin
            // skipping bytes after the terminator
            if (last_byte)
            begin
                term_next = 1'b0;
                acc_next  = '0;
                rem_next  = '0;
            end
        end
        else if (rem_reg != '0)
        begin
            // continuation byte
            if (rem_dec == '0)
            begin
                res.code_point  = acc_shift;
                res.has_char    = 1'b1;
                res.end_of_text = last_byte;
                res_valid       = 1'b1;
                acc_next        = '0;
                rem_next        = '0;
            end
            else if (last_byte)
            begin
                res.truncated   = 1'b1;
                res.end_of_text = 1'b1;
                res_valid       = 1'b1;
                acc_next        = '0;
                rem_next        = '0;
            end
            else
            begin
                acc_next = acc_shift;
                rem_next = rem_dec;
            end
        end
        else if (byte_value == '0)
        begin
            // terminator
            res.end_of_text = 1'b1;
            res_valid       = 1'b1;
            acc_next        = '0;
            rem_next        = '0;
            term_next       = !last_byte;
        end
        else if ((byte_value & utf8_pkg::ASCII_MASK) == '0)
        begin
            res.code_point  = {{(utf8_pkg::CP_W-utf8_pkg::BYTE_W){1'b0}}, byte_value};
            res.has_char    = 1'b1;
            res.end_of_text = last_byte;
            res_valid       = 1'b1;
            acc_next        = '0;
        end
        else
        begin
            // multibyte lead or bad lead
            res_valid = 1'b0;
            if ((byte_value & utf8_pkg::LEAD2_MASK) == utf8_pkg::LEAD2_PAT)
            begin
                acc_next = {26'd0, byte_value[4:0]};
                rem_next = 3'd1;
            end
            else if ((byte_value & utf8_pkg::LEAD3_MASK) == utf8_pkg::LEAD3_PAT)
            begin
                acc_next = {27'd0, byte_value[3:0]};
                rem_next = 3'd2;
            end
            else if ((byte_value & utf8_pkg::LEAD4_MASK) == utf8_pkg::LEAD4_PAT)
            begin
                acc_next = {28'd0, byte_value[2:0]};
                rem_next = 3'd3;
            end
            else if ((byte_value & utf8_pkg::LEAD5_MASK) == utf8_pkg::LEAD5_PAT)
            begin
                acc_next = {29'd0, byte_value[1:0]};
                rem_next = 3'd4;
            end
            else if ((byte_value & utf8_pkg::LEAD6_MASK) == utf8_pkg::LEAD6_PAT)
            begin
                acc_next = {30'd0, byte_value[0]};
                rem_next = 3'd5;
            end
            else
            begin
                res.code_point  = utf8_pkg::REPLACEMENT_CHAR;
                res.has_char    = 1'b1;
                res.bad_lead    = 1'b1;
                res.end_of_text = last_byte;
                res_valid       = 1'b1;
                acc_next        = '0;
            end

            // last byte right after a lead: truncated sequence
            if (!res_valid && last_byte)
            begin
                res.truncated   = 1'b1;
                res.end_of_text = 1'b1;
                res_valid       = 1'b1;
                acc_next        = '0;
                rem_next        = '0;
            end
        end
    end

    // Output register with skid entry
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire && res_valid)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire && res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            rem_reg        <= '0;
            term_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                acc_reg  <= acc_next;
                rem_reg  <= rem_next;
                term_reg <= term_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = out_reg.code_point;
    assign has_char    = out_reg.has_char;
    assign bad_lead    = out_reg.bad_lead;
    assign truncated   = out_reg.truncated;
    assign end_of_text = out_reg.end_of_text;

endmodule

@@ hdl/utf8_checker.sv @@
// ============================================================================
// utf8_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ============================================================================
module utf8_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [utf8_pkg::BYTE_W-1:0]  byte_value,
    input logic                         last_byte,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [utf8_pkg::CP_W-1:0]    code_point,
    input logic                         has_char,
    input logic                         bad_lead,
    input logic                         truncated,
    input logic                         end_of_text
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(end_of_text))
        else $error("stalled result changed");

    // input stalls only while a result is pending
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with empty output");

    // bad lead carries the replacement character
    a_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_lead |->
            has_char && !truncated && code_point == utf8_pkg::REPLACEMENT_CHAR)
        else $error("bad lead item malformed");

    // truncation closes the string without a character
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> !has_char && end_of_text && code_point == '0)
        else $error("truncated item malformed");

    // no character means zero code point and end of string
    a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> code_point == '0 && end_of_text)
        else $error("empty item malformed");

endmodule

bind utf8_stream_decoder utf8_checker u_utf8_checker (.*);
